[src/dwpd_pkg.sv]
// ----------------------------------------------------------------------------
// dwpd_pkg
// Types and constants of the dual-wiper pot decoder.
// ----------------------------------------------------------------------------
package dwpd_pkg;

  localparam int unsigned DIV_NUM_W = 36;
  localparam int unsigned DIV_DEN_W = 20;
  localparam int unsigned CFG_IDX_W = 4;

  localparam logic signed [31:0] ONE_Q      = 32'sd65536;
  localparam logic signed [31:0] TWO_Q      = 32'sd131072;
  localparam logic signed [31:0] WRAP_LIM   = 32'sd117965;
  localparam logic signed [32:0] RATE_NUM   = 33'sd500000;
  localparam logic signed [31:0] S32_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN    = 32'sh8000_0000;
  localparam logic [63:0]        GAIN_LIMIT = 64'h0000_7FFF_0000_0000;

  localparam logic [2:0]  RST_MODE   = 3'd0;
  localparam logic [16:0] RST_DZ     = 17'd0;
  localparam logic [30:0] RST_THR    = 31'd0;
  localparam logic [30:0] RST_FAC    = 31'd0;
  localparam logic signed [31:0] RST_STEP  = 32'sd65536;
  localparam logic [16:0] RST_SMOOTH = 17'd65536;
  localparam logic signed [31:0] RST_LOWER = -32'sd65536;
  localparam logic signed [31:0] RST_UPPER = 32'sd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_THR   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_FAC   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER     = 4'd7;

  typedef enum logic [4:0] {
    S_IDLE, S_PRE, S_DA, S_DAW, S_DBW, S_T12, S_W, S_M1, S_M2, S_T3,
    S_RN, S_RD, S_RW, S_ACC, S_SQ, S_HF, S_LF, S_GN, S_DG, S_DGR,
    S_STEP, S_NV, S_SM1, S_SM2, S_FIN
  } dwpd_state_t;

endpackage

[src/dwpd_in_if.sv]
// ----------------------------------------------------------------------------
// dwpd_in_if
// Input item channel of the pot decoder.
// ----------------------------------------------------------------------------
interface dwpd_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [9:0]         wiper_a;
  logic [9:0]         wiper_b;
  logic [19:0]        elapsed_us;
  logic signed [31:0] preset_value;
  logic [15:0]        holdoff_count;

  modport source (output valid, func, wiper_a, wiper_b, elapsed_us, preset_value,
                  holdoff_count, input ready);
  modport sink (input valid, func, wiper_a, wiper_b, elapsed_us, preset_value,
                holdoff_count, output ready);
endinterface

[src/dwpd_out_if.sv]
// ----------------------------------------------------------------------------
// dwpd_out_if
// Result channel of the pot decoder.
// ----------------------------------------------------------------------------
interface dwpd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] position_value;
  logic signed [31:0] turn_rate;

  modport source (output valid, position_value, turn_rate, input ready);
  modport sink (input valid, position_value, turn_rate, output ready);
endinterface

[src/dwpd_cfg_if.sv]
// ----------------------------------------------------------------------------
// dwpd_cfg_if
// Register write channel of the pot decoder.
// ----------------------------------------------------------------------------
interface dwpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

[src/dwpd_div.sv]
// ----------------------------------------------------------------------------
// dwpd_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dwpd_div
  import dwpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam int unsigned CW = $clog2(DIV_NUM_W);
  localparam logic [CW-1:0] LAST = CW'(DIV_NUM_W - 1);

  logic                 busy_r, done_r;
  logic [CW-1:0]        cnt_r;
  logic [DIV_DEN_W-1:0] rem_r, den_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W:0]   shifted, diff;
  logic                 ge;

  assign shifted = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[src/dual_wiper_pot_decoder_top.sv]
// ----------------------------------------------------------------------------
// dual_wiper_pot_decoder_top
// Dual-wiper continuous pot decoder: angle blend, rate, acceleration,
// scaling, smoothing and soft limits in Q16.16.
//
//   channel   dir  handshake     payload
//   in_ch     in   valid/ready   func, wiper_a, wiper_b, elapsed_us,
//                                preset_value, holdoff_count
//   out_ch    out  valid/ready   position_value, turn_rate
//   cfg_ch    in   valid/ready   reg_index, wdata (ready always high)
//
// A sample item makes three passes of the shared 36-step divider (two wiper
// maps, one rate, skipped when elapsed_us is zero) and up to eleven products
// of the shared 33x33 multiplier, the most when acceleration applies.
// in_ch.ready is high only in the idle state; a result waits in the output
// register and a finished item holds in its last state until it drains.
// Reset (rst_n, synchronous) restores state, config and tracking registers to defaults.
// ----------------------------------------------------------------------------
module dual_wiper_pot_decoder_top
  import dwpd_pkg::*;
#(
  parameter int ADC_FULL_SCALE = 1023
) (
  input logic        clk,
  input logic        rst_n,
  dwpd_in_if.sink    in_ch,
  dwpd_out_if.source out_ch,
  dwpd_cfg_if.sink   cfg_ch
);

  localparam logic [15:0] FS      = 16'(ADC_FULL_SCALE);
  localparam logic [15:0] HALF_FS = 16'(ADC_FULL_SCALE / 2);

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'(S32_MAX)) return S32_MAX;
    if (v < 66'(S32_MIN)) return S32_MIN;
    return v[31:0];
  endfunction

  dwpd_state_t state_r, state_nxt;

  logic [2:0]         mode_r;
  logic [16:0]        dz_r, sm_r;
  logic [30:0]        thr_r, fac_r;
  logic signed [31:0] step_r, lower_r, upper_r;

  logic signed [31:0] last_r, ov_r;
  logic [15:0]        hold_r;

  logic [9:0]         wa_r, wb_r;
  logic [19:0]        el_r;
  logic signed [31:0] pre_val_r;
  logic [15:0]        pre_hold_r;

  logic signed [18:0] a1_r, a2_r;
  logic signed [20:0] t1_r, t2_r;
  logic [16:0]        w_r;
  logic signed [65:0] acc_r, p_r;
  logic signed [31:0] t3_r, delta_r, rate_r, nv_r;
  logic signed [32:0] accel_r;
  logic [31:0]        sqlo_r;
  logic [46:0]        hf_r;
  logic [30:0]        gain_r;

  logic               out_valid_r;
  logic signed [31:0] out_pos_r, out_rate_r;

  logic                 div_start, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic signed [32:0]   mult_a, mult_b;
  logic                 out_free, in_xfer;

  dwpd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  // wiper map
  logic [15:0]        wsel, wcl;
  logic signed [18:0] wmap, wmap_inv;
  logic               inv_sel;
  always_comb begin
    wsel     = (state_r == S_DA) ? {6'd0, wa_r} : {6'd0, wb_r};
    wcl      = (wsel > FS) ? FS : wsel;
    wmap     = 19'sd65536 - $signed({1'b0, div_quo[17:0]});
    inv_sel  = (state_r == S_DAW) ? mode_r[0] : mode_r[1];
    wmap_inv = inv_sel ? -wmap : wmap;
  end

  // angle estimates
  logic signed [20:0] t1_c, t2_c, t2_w;
  always_comb begin
    t1_c = (a2_r > 0) ? (21'(a1_r) - 21'sd65536) : (21'sd65536 - 21'(a1_r));
    t1_c = t1_c >>> 1;
    t2_w = (a1_r < 0) ? (21'(a2_r) - 21'sd131072) : -21'(a2_r);
    t2_w = t2_w >>> 1;
    t2_c = (t2_w < -21'sd65536) ? t2_w + 21'sd131072 : t2_w;
  end

  // blend weight
  logic [65:0]        prod_mag;
  logic signed [21:0] w_c;
  always_comb begin
    prod_mag = p_r[65] ? 66'(-p_r) : 66'(p_r);
    w_c = 22'sd65536 + $signed({5'd0, dz_r}) - $signed({2'b0, prod_mag[35:16]});
  end

  // blended angle and wrapped change
  logic signed [65:0] blend_sum;
  logic signed [31:0] t3_c;
  logic signed [33:0] d0, d1, d2;
  always_comb begin
    blend_sum = acc_r + p_r;
    t3_c = blend_sum[47:16];
    d0 = 34'(t3_c) - 34'(last_r);
    d1 = (d0 < -34'(WRAP_LIM)) ? d0 + 34'(TWO_Q) : d0;
    d2 = (d1 > 34'(WRAP_LIM)) ? d1 - 34'(TWO_Q) : d1;
  end

  // rate from divider
  logic signed [31:0] rate_c, rate_z;
  logic signed [32:0] delta_abs, rate_abs, accel_c;
  logic               accel_go;
  always_comb begin
    delta_abs = delta_r[31] ? -33'(delta_r) : 33'(delta_r);
    if (!delta_r[31]) begin
      rate_c = (div_quo > 36'h0_7FFF_FFFF) ? S32_MAX : div_quo[31:0];
    end else begin
      rate_c = (div_quo > 36'h0_8000_0000) ? S32_MIN : -div_quo[31:0];
    end
    if (delta_r > 0) begin
      rate_z = S32_MAX;
    end else if (delta_r < 0) begin
      rate_z = S32_MIN;
    end else begin
      rate_z = '0;
    end
    rate_abs = rate_r[31] ? -33'(rate_r) : 33'(rate_r);
    accel_c  = rate_abs - $signed({2'b0, thr_r});
    accel_go = (hold_r == '0) && (fac_r != '0) && (accel_c > 0);
  end

  // acceleration gain
  logic [63:0] gp;
  logic        gcap;
  always_comb begin
    gp   = {hf_r[31:0], 32'd0} + 64'(p_r[63:0]);
    gcap = (|hf_r[46:15]) || (gp >= GAIN_LIMIT);
  end

  // scaled value and smoothed result
  logic signed [65:0] nv_sum, fin_sum;
  logic signed [31:0] fin_v, fin_c;
  always_comb begin
    nv_sum  = 66'(ov_r) + (p_r >>> 16);
    fin_sum = acc_r + p_r;
    fin_v   = fin_sum[47:16];
    fin_c   = fin_v;
    if (mode_r[2]) begin
      if (fin_c > upper_r) fin_c = upper_r;
      if (fin_c < lower_r) fin_c = lower_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_xfer) state_nxt = in_ch.func ? S_PRE : S_DA;
      S_PRE:  if (out_free) state_nxt = S_IDLE;
      S_DA:   state_nxt = S_DAW;
      S_DAW:  if (div_done) state_nxt = S_DBW;
      S_DBW:  if (div_done) state_nxt = S_T12;
      S_T12:  state_nxt = S_W;
      S_W:    state_nxt = S_M1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_T3;
      S_T3:   state_nxt = S_RN;
      S_RN:   state_nxt = (el_r == '0) ? S_ACC : S_RD;
      S_RD:   state_nxt = S_RW;
      S_RW:   if (div_done) state_nxt = S_ACC;
      S_ACC:  state_nxt = accel_go ? S_SQ : S_STEP;
      S_SQ:   state_nxt = S_HF;
      S_HF:   state_nxt = S_LF;
      S_LF:   state_nxt = S_GN;
      S_GN:   state_nxt = S_DG;
      S_DG:   state_nxt = S_DGR;
      S_DGR:  state_nxt = S_STEP;
      S_STEP: state_nxt = S_NV;
      S_NV:   state_nxt = S_SM1;
      S_SM1:  state_nxt = S_SM2;
      S_SM2:  state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state_r == S_IDLE);
    cfg_ch.ready = 1'b1;
    div_start = 1'b0;
    div_num   = {{(DIV_NUM_W-33){1'b0}}, wcl, 17'd0} + DIV_NUM_W'(HALF_FS);
    div_den   = DIV_DEN_W'(FS);
    mult_a    = '0;
    mult_b    = '0;
    case (state_r)
      S_DA:  div_start = 1'b1;
      S_DAW: div_start = div_done;
      S_RD: begin
        div_start = 1'b1;
        div_num   = p_r[DIV_NUM_W-1:0];
        div_den   = el_r;
      end
      S_T12: begin
        mult_a = 33'(a1_r);
        mult_b = 33'sd65536 + $signed({15'd0, dz_r, 1'b0});
      end
      S_M1: begin
        mult_a = 33'(t1_r);
        mult_b = $signed({16'd0, w_r});
      end
      S_M2: begin
        mult_a = 33'(t2_r);
        mult_b = 33'sd65536 - $signed({16'd0, w_r});
      end
      S_RN: begin
        mult_a = delta_abs;
        mult_b = RATE_NUM;
      end
      S_SQ: begin
        mult_a = accel_r;
        mult_b = accel_r;
      end
      S_HF: begin
        mult_a = $signed({18'd0, p_r[62:48]});
        mult_b = $signed({2'b0, fac_r});
      end
      S_LF: begin
        mult_a = $signed({1'b0, sqlo_r});
        mult_b = $signed({2'b0, fac_r});
      end
      S_DG: begin
        mult_a = 33'(delta_r);
        mult_b = $signed({2'b0, gain_r});
      end
      S_STEP: begin
        mult_a = 33'(delta_r);
        mult_b = 33'(step_r);
      end
      S_SM1: begin
        mult_a = 33'(nv_r);
        mult_b = $signed({16'd0, sm_r});
      end
      S_SM2: begin
        mult_a = 33'(ov_r);
        mult_b = 33'sd65536 - $signed({16'd0, sm_r});
      end
      default: ;
    endcase
  end

  // hold the last product while a finished item waits
  always_ff @(posedge clk) begin
    if (state_r != S_FIN) p_r <= mult_a * mult_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= RST_MODE;
      dz_r        <= RST_DZ;
      thr_r       <= RST_THR;
      fac_r       <= RST_FAC;
      step_r      <= RST_STEP;
      sm_r        <= RST_SMOOTH;
      lower_r     <= RST_LOWER;
      upper_r     <= RST_UPPER;
      last_r      <= '0;
      ov_r        <= '0;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.reg_index)
          CFG_MODE:      mode_r <= cfg_ch.wdata[2:0];
          CFG_DEAD_ZONE: dz_r <= cfg_ch.wdata[16] ? 17'd65536 : cfg_ch.wdata[16:0];
          CFG_ACC_THR:   thr_r <= cfg_ch.wdata[30:0];
          CFG_ACC_FAC:   fac_r <= cfg_ch.wdata[30:0];
          CFG_STEP:      step_r <= cfg_ch.wdata;
          CFG_SMOOTH:    sm_r <= cfg_ch.wdata[16] ? 17'd65536 : cfg_ch.wdata[16:0];
          CFG_LOWER:     lower_r <= cfg_ch.wdata;
          CFG_UPPER:     upper_r <= cfg_ch.wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == S_PRE && out_free) begin
        ov_r        <= pre_val_r;
        hold_r      <= pre_hold_r;
        out_valid_r <= 1'b1;
      end
      if (state_r == S_FIN && out_free) begin
        ov_r        <= fin_c;
        last_r      <= t3_r;
        out_valid_r <= 1'b1;
        if (hold_r != '0) hold_r <= hold_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      wa_r       <= in_ch.wiper_a;
      wb_r       <= in_ch.wiper_b;
      el_r       <= in_ch.elapsed_us;
      pre_val_r  <= in_ch.preset_value;
      pre_hold_r <= in_ch.holdoff_count;
    end
    case (state_r)
      S_DAW: if (div_done) a1_r <= wmap_inv;
      S_DBW: if (div_done) a2_r <= wmap_inv;
      S_T12: begin
        t1_r <= t1_c;
        t2_r <= t2_c;
      end
      S_W: begin
        if (w_c < 0) begin
          w_r <= '0;
        end else if (w_c > 22'sd65536) begin
          w_r <= 17'd65536;
        end else begin
          w_r <= w_c[16:0];
        end
      end
      S_M2: acc_r <= p_r;
      S_T3: begin
        t3_r    <= t3_c;
        delta_r <= d2[31:0];
      end
      S_RN: if (el_r == '0) rate_r <= rate_z;
      S_RW: if (div_done) rate_r <= rate_c;
      S_ACC: accel_r <= accel_c;
      S_HF: sqlo_r <= p_r[47:16];
      S_LF: hf_r <= p_r[46:0];
      S_GN: gain_r <= gcap ? 31'h7FFF_FFFF : 31'd65536 + gp[46:16];
      S_DGR: delta_r <= sat32(p_r >>> 16);
      S_NV: nv_r <= sat32(nv_sum);
      S_SM2: acc_r <= p_r;
      S_PRE: begin
        if (out_free) begin
          out_pos_r  <= pre_val_r;
          out_rate_r <= '0;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_pos_r  <= fin_c;
          out_rate_r <= rate_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.position_value = out_pos_r;
  assign out_ch.turn_rate      = out_rate_r;

`ifndef NO_ASSERTIONS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("accepted item did not start work");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN || $past(state_r) == S_PRE))
    else $error("result appeared outside commit");

  a_preset_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PRE && out_free) |=> (out_rate_r == '0 && out_valid_r))
    else $error("preset result carries nonzero rate");

  a_div_start_states: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == S_DA || state_r == S_DAW || state_r == S_RD))
    else $error("divider started from wrong state");

  a_hold_kept_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_FIN && state_r != S_PRE && $past(state_r) != S_FIN
     && $past(state_r) != S_PRE && $past(rst_n)) |-> $stable(hold_r))
    else $error("hold-off count changed mid item");
`endif

endmodule
